// ----- rtl/assert_macros.svh -----
// assertion macros shared by the front, queue and back end modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every active clock edge
`define ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/phbt_pkg.sv -----
// shared types and constants for the print head band transpose block
`timescale 1ns / 1ps

package phbt_pkg;

    localparam logic [13:0] MAX_WIDTH      = 14'd8192;
    localparam logic [3:0]  MAX_HEAD_BYTES = 4'd8;
    localparam logic [12:0] MAX_ROW_INDEX  = 13'd8191;

    localparam int QDEPTH   = 4;
    localparam int QIDX_W   = $clog2(QDEPTH);
    localparam int QCOUNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        REG_WIDTH_PIXELS  = 2'd0,
        REG_HEAD_BYTES    = 2'd1,
        REG_START_ROW     = 2'd2,
        REG_INVERT_SOURCE = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [13:0] width_pixels;
        logic [3:0]  head_bytes;
        logic [12:0] start_row;
        logic        invert_source;
    } cfg_t;

    // one classified request waiting for the back end
    typedef struct packed {
        logic [7:0][7:0] col_bytes;
        logic [15:0]     base_offset;
        logic [3:0]      step;
        logic [3:0]      npix;
        logic            band_end;
        logic            all_zero;
        logic [13:0]     max_right;
    } entry_t;

endpackage

// ----- rtl/phbt_front.sv -----
// front end: classifies a request, masks and transposes rows, tracks band summary
`timescale 1ns / 1ps
`include "assert_macros.svh"

module phbt_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  phbt_pkg::cfg_t      cfg,
    input  logic                in_valid,
    input  logic                room,
    input  logic [9:0]          byte_column,
    input  logic [2:0]          head_byte,
    input  logic [63:0]         source_rows,
    input  logic                band_end,
    output logic                push,
    output phbt_pkg::entry_t    entry
);

    logic        seen_reg, seen_next;
    logic [13:0] rightmost_reg, rightmost_next;

    logic [13:0] w_eff;
    logic [13:0] w_round;
    logic [10:0] ncols;
    logic [3:0]  nhb;
    logic [12:0] top_row;
    logic        item_ok;
    logic        last_col;
    logic [3:0]  npix;
    logic [7:0]  mask;
    logic [7:0]  rows [8];
    logic [7:0]  or_all;
    logic [3:0]  right_edge;
    logic [13:0] right_pos;
    logic        hit;
    logic        cur_seen;
    logic [13:0] cur_right;
    logic [13:0] col_prod;
    logic        accept;
    logic [7:0][7:0] tbytes;

    assign accept = in_valid && room;

    always_comb begin
        w_eff   = (cfg.width_pixels > phbt_pkg::MAX_WIDTH) ? phbt_pkg::MAX_WIDTH
                                                           : cfg.width_pixels;
        w_round = w_eff + 14'd7;
        ncols   = w_round[13:3];
        nhb     = (cfg.head_bytes > phbt_pkg::MAX_HEAD_BYTES) ? phbt_pkg::MAX_HEAD_BYTES
                                                              : cfg.head_bytes;
        top_row = (cfg.start_row > phbt_pkg::MAX_ROW_INDEX) ? phbt_pkg::MAX_ROW_INDEX
                                                            : cfg.start_row;
        item_ok  = ({1'b0, byte_column} < ncols) && ({1'b0, head_byte} < nhb);
        last_col = (({1'b0, byte_column} + 11'd1) == ncols);
        if (last_col && (w_eff[2:0] != 3'd0)) begin
            npix = {1'b0, w_eff[2:0]};
        end else begin
            npix = 4'd8;
        end
        mask = ~(8'hFF >> npix);
    end

    // rows above the bitmap top stay zero and are not inverted
    always_comb begin
        or_all = '0;
        for (int i = 0; i < 8; i++) begin
            if ({7'd0, head_byte, 3'(i)} <= top_row) begin
                rows[i] = (source_rows[8*i +: 8] ^ {8{cfg.invert_source}}) & mask;
            end else begin
                rows[i] = '0;
            end
            or_all = or_all | rows[i];
        end
    end

    // lowest set bit wins: it is the rightmost pixel
    always_comb begin
        right_edge = '0;
        for (int k = 7; k >= 0; k--) begin
            if (or_all[k]) begin
                right_edge = 4'(8 - k);
            end
        end
        right_pos = {1'b0, byte_column, 3'b000} + {10'd0, right_edge};
        hit       = item_ok && (or_all != 8'd0);
        cur_seen  = seen_reg || hit;
        cur_right = (hit && (right_pos > rightmost_reg)) ? right_pos : rightmost_reg;
    end

    always_comb begin
        for (int p = 0; p < 8; p++) begin
            for (int i = 0; i < 8; i++) begin
                tbytes[p][7-i] = rows[i][7-p];
            end
        end
    end

    assign col_prod = 14'(byte_column) * 14'(nhb);

    always_comb begin
        push = accept && (item_ok || band_end);
        entry.band_end  = band_end;
        entry.all_zero  = !cur_seen;
        entry.max_right = cur_right;
        if (item_ok) begin
            entry.col_bytes   = tbytes;
            entry.base_offset = 16'({col_prod, 3'b000}) + {13'd0, head_byte};
            entry.step        = nhb;
            entry.npix        = npix;
        end else begin
            // summary-only result for a void band end
            entry.col_bytes   = '0;
            entry.base_offset = '0;
            entry.step        = '0;
            entry.npix        = 4'd1;
        end
    end

    always_comb begin
        seen_next      = seen_reg;
        rightmost_next = rightmost_reg;
        if (accept) begin
            if (band_end) begin
                seen_next      = 1'b0;
                rightmost_next = '0;
            end else begin
                seen_next      = cur_seen;
                rightmost_next = cur_right;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg      <= 1'b0;
            rightmost_reg <= '0;
        end else begin
            seen_reg      <= seen_next;
            rightmost_reg <= rightmost_next;
        end
    end

    `ASSERT_NEXT(a_band_clear, aclk, aresetn, accept && band_end, !seen_reg && (rightmost_reg == 14'd0))

endmodule

// ----- rtl/phbt_queue.sv -----
// short request queue between front and back end
`timescale 1ns / 1ps
`include "assert_macros.svh"

module phbt_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  phbt_pkg::entry_t    push_entry,
    input  logic                pop,
    output logic                full,
    output logic                not_empty,
    output phbt_pkg::entry_t    head
);

    phbt_pkg::entry_t mem [phbt_pkg::QDEPTH];

    logic [phbt_pkg::QIDX_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [phbt_pkg::QIDX_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [phbt_pkg::QCOUNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == phbt_pkg::QCOUNT_W'(phbt_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_NEXT(a_fill_tracks, aclk, aresetn, push && !pop, count_reg == ($past(count_reg) + 1'b1))
    `ASSERT_IMPLY(a_no_pop_empty, aclk, aresetn, pop, not_empty)

endmodule

// ----- rtl/phbt_back.sv -----
// back end: steps through pixel columns of the head request into the result register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module phbt_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  phbt_pkg::entry_t    head,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_column_byte,
    output logic [15:0]         m_buffer_offset,
    output logic                m_last,
    output logic                m_band_done,
    output logic                m_band_all_zero,
    output logic [13:0]         m_band_max_right
);

    logic [2:0]  pix_reg, pix_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_column_byte_reg;
    logic [15:0] m_buffer_offset_reg;
    logic        m_last_reg;
    logic        m_band_done_reg;
    logic        m_band_all_zero_reg;
    logic [13:0] m_band_max_right_reg;

    logic        load;
    logic        is_last;
    logic        done;
    logic [6:0]  step_off;

    always_comb begin
        load     = head_valid && (!m_valid_reg || m_ready);
        is_last  = (({1'b0, pix_reg} + 4'd1) == head.npix);
        done     = is_last && head.band_end;
        pop      = load && is_last;
        step_off = 7'(pix_reg) * 7'(head.step);
        pix_next = pix_reg;
        if (load) begin
            pix_next = is_last ? 3'd0 : pix_reg + 3'd1;
        end
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pix_reg     <= pix_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_column_byte_reg    <= head.col_bytes[pix_reg];
            m_buffer_offset_reg  <= head.base_offset + {9'd0, step_off};
            m_last_reg           <= is_last;
            m_band_done_reg      <= done;
            m_band_all_zero_reg  <= done && head.all_zero;
            m_band_max_right_reg <= done ? head.max_right : 14'd0;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_column_byte    = m_column_byte_reg;
    assign m_buffer_offset  = m_buffer_offset_reg;
    assign m_last           = m_last_reg;
    assign m_band_done      = m_band_done_reg;
    assign m_band_all_zero  = m_band_all_zero_reg;
    assign m_band_max_right = m_band_max_right_reg;

    // a column byte that is not the last one is always followed by the next
    `ASSERT_NEXT(a_burst_continues, aclk, aresetn, m_valid_reg && m_ready && !m_last_reg, m_valid_reg)
    `ASSERT_IMPLY(a_summary_on_done, aclk, aresetn, m_valid_reg && !m_band_done_reg, !m_band_all_zero_reg && (m_band_max_right_reg == 14'd0))

endmodule

// ----- rtl/print_head_band_transpose.sv -----
// top level: configuration registers and the front, queue and back end
`timescale 1ns / 1ps

// Turns one request (eight stacked source bytes of a byte column for one head
// byte) into one transposed print-head byte per pixel column on the m_ channel,
// each with its buffer offset. A request gives one result per pixel column: 8
// on a full byte column, width mod 8 on a partial last one, 1 for a summary-only
// band end, 0 for a void request, all through the single result register. The
// front takes a request in every cycle while the four-entry queue has room; a
// taken request is written into the queue and its results are registered in the
// result register. Band summary fields are nonzero only on the result that
// carries band_done. Configuration goes through the APB port at byte addresses
// 0, 4, 8 and 12 (width_pixels, head_bytes, start_row, invert_source); the user
// is to write it only while the block is idle; the block does not enforce this.
module print_head_band_transpose (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [9:0]  s_byte_column,
    input  logic [2:0]  s_head_byte,
    input  logic [63:0] s_source_rows,
    input  logic        s_band_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_column_byte,
    output logic [15:0] m_buffer_offset,
    output logic        m_last,
    output logic        m_band_done,
    output logic        m_band_all_zero,
    output logic [13:0] m_band_max_right
);

    logic [13:0] width_pixels_reg;
    logic [3:0]  head_bytes_reg;
    logic [12:0] start_row_reg;
    logic        invert_source_reg;

    phbt_pkg::cfg_t     cfg;
    phbt_pkg::entry_t   push_entry;
    phbt_pkg::entry_t   head;
    phbt_pkg::cfg_reg_t reg_sel;
    logic               cfg_write;
    logic               push;
    logic               pop;
    logic               full;
    logic               not_empty;

    assign pready    = 1'b1;
    assign reg_sel   = phbt_pkg::cfg_reg_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_pixels_reg  <= 14'd8192;
            head_bytes_reg    <= 4'd3;
            start_row_reg     <= 13'd23;
            invert_source_reg <= 1'b0;
        end else if (cfg_write) begin
            case (reg_sel)
                phbt_pkg::REG_WIDTH_PIXELS:  width_pixels_reg  <= pwdata[13:0];
                phbt_pkg::REG_HEAD_BYTES:    head_bytes_reg    <= pwdata[3:0];
                phbt_pkg::REG_START_ROW:     start_row_reg     <= pwdata[12:0];
                phbt_pkg::REG_INVERT_SOURCE: invert_source_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            phbt_pkg::REG_WIDTH_PIXELS:  prdata = {18'd0, width_pixels_reg};
            phbt_pkg::REG_HEAD_BYTES:    prdata = {28'd0, head_bytes_reg};
            phbt_pkg::REG_START_ROW:     prdata = {19'd0, start_row_reg};
            phbt_pkg::REG_INVERT_SOURCE: prdata = {31'd0, invert_source_reg};
            default:                     prdata = '0;
        endcase
    end

    assign cfg.width_pixels  = width_pixels_reg;
    assign cfg.head_bytes    = head_bytes_reg;
    assign cfg.start_row     = start_row_reg;
    assign cfg.invert_source = invert_source_reg;

    assign s_ready = !full;

    phbt_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .in_valid    (s_valid),
        .room        (!full),
        .byte_column (s_byte_column),
        .head_byte   (s_head_byte),
        .source_rows (s_source_rows),
        .band_end    (s_band_end),
        .push        (push),
        .entry       (push_entry)
    );

    phbt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .not_empty  (not_empty),
        .head       (head)
    );

    phbt_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_valid       (not_empty),
        .head             (head),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_column_byte    (m_column_byte),
        .m_buffer_offset  (m_buffer_offset),
        .m_last           (m_last),
        .m_band_done      (m_band_done),
        .m_band_all_zero  (m_band_all_zero),
        .m_band_max_right (m_band_max_right)
    );

endmodule
